### hw/rtl/crbe_pkg.sv
`default_nettype none
package crbe_pkg;

  localparam int SURFACES_DEFAULT   = 4;
  localparam int MAX_WIDTH_DEFAULT  = 64;
  localparam int MAX_HEIGHT_DEFAULT = 64;

  // The slot field is two bits wide, so at most four slots can be named.
  localparam int SLOTS = 4;

  typedef enum logic [2:0] {
    CMD_CREATE      = 3'd0,
    CMD_DELETE      = 3'd1,
    CMD_FILL        = 3'd2,
    CMD_CHUNK_START = 3'd3,
    CMD_CHUNK_PIXEL = 3'd4,
    CMD_FLIP        = 3'd5,
    CMD_BLIT        = 3'd6,
    CMD_READ        = 3'd7
  } cmd_t;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_INVALID      = 3'd1;
  localparam logic [2:0] ST_SRC_INVALID  = 3'd2;
  localparam logic [2:0] ST_DST_INVALID  = 3'd3;
  localparam logic [2:0] ST_BOTH_INVALID = 3'd4;

  typedef struct packed {
    logic [2:0]         command;
    logic [1:0]         surface;
    logic [1:0]         second_surface;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [11:0]        width;
    logic [11:0]        height;
    logic signed [11:0] dest_x;
    logic signed [11:0] dest_y;
    logic [23:0]        color;
    logic               flip_top_bottom;
    logic               flip_left_right;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] pixel_color;
  } rsp_item_t;

  typedef struct packed {
    logic latch;
    logic setup;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic scan_done;
  } ctrl_status_t;

endpackage
`default_nettype wire

### hw/rtl/crbe_controller.sv
`default_nettype none
module crbe_controller (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_ready,
  output logic                        rsp_valid,
  input  wire logic                   rsp_ready,
  output crbe_pkg::ctrl_cmd_t         cmd,
  input  wire crbe_pkg::ctrl_status_t stat
);
  import crbe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SETUP  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.latch = req_valid;
        if (req_valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = stat.scan_needed ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/crbe_datapath.sv
`default_nettype none
module crbe_datapath #(
  parameter int SURFACES   = crbe_pkg::SURFACES_DEFAULT,
  parameter int MAX_WIDTH  = crbe_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = crbe_pkg::MAX_HEIGHT_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire crbe_pkg::req_item_t  req,
  input  wire crbe_pkg::ctrl_cmd_t  cmd,
  output crbe_pkg::ctrl_status_t    stat,
  output crbe_pkg::rsp_item_t       rsp
);
  import crbe_pkg::*;

  localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
  localparam int DEPTH = SURFACES * PLANE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (PLANE > 1) ? $clog2(PLANE) : 1;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [4:0] {
    M_CLEAR = 5'b00001,
    M_FILL  = 5'b00010,
    M_BLIT  = 5'b00100,
    M_FLIP1 = 5'b01000,
    M_FLIP2 = 5'b10000
  } mode_t;

  req_item_t it;

  logic [SLOTS-1:0] sv;
  logic [CW-1:0]    sw_tab [SLOTS];
  logic [RW-1:0]    sh_tab [SLOTS];

  logic               chunk_open;
  logic [1:0]         chunk_slot;
  logic signed [11:0] chunk_left;
  logic signed [11:0] chunk_top;
  logic [11:0]        chunk_cols;
  logic [11:0]        chunk_rows;
  logic [11:0]        ccol;
  logic [11:0]        crow;

  mode_t              mode;
  logic [1:0]         slot_s;
  logic [1:0]         slot_d;
  logic [CW-1:0]      col_lo;
  logic [CW-1:0]      col_hi;
  logic [RW-1:0]      row_hi;
  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  logic               phase;
  logic signed [13:0] off_x;
  logic signed [13:0] off_y;

  logic [2:0] res_status;
  logic       res_read;

  logic [23:0] pix_mem [DEPTH];
  logic [23:0] scr_mem [PLANE];
  logic [23:0] pix_rdata;
  logic [23:0] scr_rdata;

  // Setup-time decode of the held item.
  logic               s_ok, d_ok, c_ok;
  logic [CW-1:0]      sw, tw, cw_w;
  logic [RW-1:0]      sh, th, ch_h;
  logic signed [13:0] x14, y14, xe, ye, lo_x, lo_y, hi_x, hi_y, sw14, sh14;
  logic               rect_ok, create_ok, read_ok;
  logic signed [13:0] cabs_col, cabs_row;
  logic               cpix_in;
  mode_t              setup_mode;
  logic               scan_needed;

  assign s_ok = (int'(it.surface) < SURFACES) && sv[it.surface];
  assign d_ok = (int'(it.second_surface) < SURFACES) && sv[it.second_surface];
  assign c_ok = chunk_open && (int'(chunk_slot) < SURFACES) && sv[chunk_slot];
  assign sw   = sw_tab[it.surface];
  assign sh   = sh_tab[it.surface];
  assign tw   = sw_tab[slot_d];
  assign th   = sh_tab[slot_d];
  assign cw_w = sw_tab[chunk_slot];
  assign ch_h = sh_tab[chunk_slot];

  always_comb begin
    x14  = 14'(it.x);
    y14  = 14'(it.y);
    xe   = x14 + $signed({2'b00, it.width});
    ye   = y14 + $signed({2'b00, it.height});
    sw14 = $signed(14'(sw));
    sh14 = $signed(14'(sh));
    lo_x = (x14 < 0) ? 14'sd0 : x14;
    lo_y = (y14 < 0) ? 14'sd0 : y14;
    hi_x = (xe < sw14) ? xe : sw14;
    hi_y = (ye < sh14) ? ye : sh14;
    rect_ok   = (hi_x > lo_x) && (hi_y > lo_y);
    create_ok = (int'(it.surface) < SURFACES) && !sv[it.surface] &&
                (int'(it.width) <= MAX_WIDTH) && (int'(it.height) <= MAX_HEIGHT);
    read_ok   = s_ok && (x14 >= 0) && (y14 >= 0) && (x14 < sw14) && (y14 < sh14);
    cabs_col  = 14'(chunk_left) + $signed({2'b00, ccol});
    cabs_row  = 14'(chunk_top) + $signed({2'b00, crow});
    cpix_in   = (cabs_col >= 0) && (cabs_row >= 0) &&
                (cabs_col < $signed(14'(cw_w))) && (cabs_row < $signed(14'(ch_h)));
  end

  always_comb begin
    scan_needed = 1'b0;
    setup_mode  = M_FILL;
    case (cmd_t'(it.command))
      CMD_CREATE: begin
        scan_needed = create_ok;
        setup_mode  = M_CLEAR;
      end
      CMD_FILL: begin
        scan_needed = s_ok && rect_ok;
        setup_mode  = M_FILL;
      end
      CMD_BLIT: begin
        scan_needed = s_ok && d_ok && rect_ok;
        setup_mode  = M_BLIT;
      end
      CMD_FLIP: begin
        scan_needed = s_ok && (it.flip_top_bottom || it.flip_left_right) &&
                      (sw != '0) && (sh != '0);
        setup_mode  = M_FLIP1;
      end
      default: scan_needed = 1'b0;
    endcase
  end

  assign stat.scan_needed = scan_needed;

  // Scan sequencing.
  logic               needs_read, adv, last, col_wrap;
  logic signed [14:0] tx, ty;
  logic               t_in;
  logic [CW-1:0]      sws, ti;
  logic [RW-1:0]      shs, tj;

  assign needs_read = (mode == M_BLIT) || (mode == M_FLIP1) || (mode == M_FLIP2);
  assign adv        = cmd.scan && (!needs_read || phase);
  assign col_wrap   = (col + CW'(1)) == col_hi;
  assign last       = col_wrap && ((row + RW'(1)) == row_hi);
  assign stat.scan_done = adv && last && (mode != M_FLIP1);

  assign sws = sw_tab[slot_s];
  assign shs = sh_tab[slot_s];
  assign tx  = 15'(off_x) + $signed(15'(col));
  assign ty  = 15'(off_y) + $signed(15'(row));
  assign t_in = (tx >= 0) && (ty >= 0) &&
                (tx < $signed(15'(tw))) && (ty < $signed(15'(th)));
  assign ti  = it.flip_left_right ? (sws - CW'(1) - col) : col;
  assign tj  = it.flip_top_bottom ? (shs - RW'(1) - row) : row;

  // Memory port selection.
  logic          wr_en, rd_en, sc_wr_en, sc_rd_en;
  logic [1:0]    wr_slot, rd_slot;
  logic [CW-1:0] wr_col, rd_col;
  logic [RW-1:0] wr_row, rd_row;
  logic [23:0]   wr_data;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [PW-1:0] sc_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_slot = slot_s;
    wr_col  = col;
    wr_row  = row;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_slot = slot_s;
    rd_col  = col;
    rd_row  = row;
    sc_wr_en = 1'b0;
    sc_rd_en = 1'b0;
    if (cmd.setup) begin
      if ((cmd_t'(it.command) == CMD_CHUNK_PIXEL) && c_ok && cpix_in) begin
        wr_en   = 1'b1;
        wr_slot = chunk_slot;
        wr_col  = CW'(cabs_col);
        wr_row  = RW'(cabs_row);
        wr_data = it.color;
      end
      if ((cmd_t'(it.command) == CMD_READ) && read_ok) begin
        rd_en   = 1'b1;
        rd_slot = it.surface;
        rd_col  = CW'(it.x);
        rd_row  = RW'(it.y);
      end
    end
    if (cmd.scan) begin
      case (mode)
        M_CLEAR: wr_en = 1'b1;
        M_FILL: begin
          wr_en   = 1'b1;
          wr_data = it.color;
        end
        M_BLIT: begin
          rd_en   = !phase;
          wr_en   = phase && t_in;
          wr_slot = slot_d;
          wr_col  = CW'(tx);
          wr_row  = RW'(ty);
          wr_data = pix_rdata;
        end
        M_FLIP1: begin
          rd_en    = !phase;
          sc_wr_en = phase;
        end
        M_FLIP2: begin
          sc_rd_en = !phase;
          wr_en    = phase;
          wr_col   = ti;
          wr_row   = tj;
          wr_data  = scr_rdata;
        end
        default: wr_en = 1'b0;
      endcase
    end
    wr_addr = AW'(AW'(wr_slot) * AW'(PLANE) + AW'(wr_row) * AW'(MAX_WIDTH) + AW'(wr_col));
    rd_addr = AW'(AW'(rd_slot) * AW'(PLANE) + AW'(rd_row) * AW'(MAX_WIDTH) + AW'(rd_col));
    sc_addr = PW'(PW'(row) * PW'(MAX_WIDTH) + PW'(col));
  end

  always_ff @(posedge clk) begin
    if (wr_en) pix_mem[wr_addr] <= wr_data;
    if (rd_en) pix_rdata <= pix_mem[rd_addr];
    if (sc_wr_en) scr_mem[sc_addr] <= pix_rdata;
    if (sc_rd_en) scr_rdata <= scr_mem[sc_addr];
  end

  // Item hold, scan registers and result.
  always_ff @(posedge clk) begin
    if (cmd.latch) it <= req;
    if (cmd.setup) begin
      mode   <= setup_mode;
      slot_s <= it.surface;
      slot_d <= it.second_surface;
      phase  <= 1'b0;
      off_x  <= 14'(it.dest_x) - x14;
      off_y  <= 14'(it.dest_y) - y14;
      case (setup_mode)
        M_CLEAR: begin
          col_lo <= '0;
          col    <= '0;
          row    <= '0;
          col_hi <= CW'(MAX_WIDTH);
          row_hi <= RW'(MAX_HEIGHT);
        end
        M_FLIP1: begin
          col_lo <= '0;
          col    <= '0;
          row    <= '0;
          col_hi <= sw;
          row_hi <= sh;
        end
        default: begin
          col_lo <= CW'(lo_x);
          col    <= CW'(lo_x);
          row    <= RW'(lo_y);
          col_hi <= CW'(hi_x);
          row_hi <= RW'(hi_y);
        end
      endcase
    end
    if (cmd.scan) begin
      if (needs_read) phase <= !phase;
      if (adv) begin
        if (last) begin
          if (mode == M_FLIP1) begin
            mode <= M_FLIP2;
            col  <= '0;
            row  <= '0;
          end
        end else if (col_wrap) begin
          col <= col_lo;
          row <= row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
    end
    if (cmd.finish) begin
      rsp.status      <= res_status;
      rsp.pixel_color <= res_read ? pix_rdata : 24'd0;
    end
  end

  // Surface table, chunk state and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      sv         <= '0;
      chunk_open <= 1'b0;
      chunk_slot <= '0;
      chunk_left <= '0;
      chunk_top  <= '0;
      chunk_cols <= '0;
      chunk_rows <= '0;
      ccol       <= '0;
      crow       <= '0;
      res_status <= ST_OK;
      res_read   <= 1'b0;
    end else if (cmd.setup) begin
      res_status <= ST_OK;
      res_read   <= 1'b0;
      case (cmd_t'(it.command))
        CMD_CREATE: begin
          if (create_ok) begin
            sv[it.surface]     <= 1'b1;
            sw_tab[it.surface] <= CW'(it.width);
            sh_tab[it.surface] <= RW'(it.height);
          end else begin
            res_status <= ST_INVALID;
          end
        end
        CMD_DELETE: begin
          if (s_ok) begin
            sv[it.surface] <= 1'b0;
            if (chunk_open && (chunk_slot == it.surface)) chunk_open <= 1'b0;
          end else begin
            res_status <= ST_INVALID;
          end
        end
        CMD_FILL, CMD_FLIP: begin
          if (!s_ok) res_status <= ST_INVALID;
        end
        CMD_CHUNK_START: begin
          if (s_ok) begin
            chunk_slot <= it.surface;
            chunk_left <= it.x;
            chunk_top  <= it.y;
            chunk_cols <= it.width;
            chunk_rows <= it.height;
            ccol       <= '0;
            crow       <= '0;
            chunk_open <= (it.width != '0) && (it.height != '0);
          end else begin
            chunk_open <= 1'b0;
            res_status <= ST_INVALID;
          end
        end
        CMD_CHUNK_PIXEL: begin
          if (c_ok) begin
            if (ccol + 12'd1 == chunk_cols) begin
              ccol <= '0;
              crow <= crow + 12'd1;
              if (crow + 12'd1 == chunk_rows) chunk_open <= 1'b0;
            end else begin
              ccol <= ccol + 12'd1;
            end
          end else begin
            res_status <= ST_INVALID;
          end
        end
        CMD_BLIT: begin
          if (!s_ok && !d_ok) res_status <= ST_BOTH_INVALID;
          else if (!s_ok) res_status <= ST_SRC_INVALID;
          else if (!d_ok) res_status <= ST_DST_INVALID;
        end
        CMD_READ: begin
          res_read <= read_ok;
          if (!read_ok) res_status <= ST_INVALID;
        end
        default: res_status <= ST_INVALID;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/clipped_rect_blit_engine_unit.sv
`default_nettype none
// A 2D engine over SURFACES slots of RGB surfaces held in one single-port-write pixel memory,
// taking one command item and giving one result item (status and read colour). Delete, chunk
// start, chunk pixel, read and rejected commands go from the setup state straight to the
// finish state, with no scan. Create clears the whole plane at one pixel a cycle; fill writes
// its clipped area at one pixel a cycle; blit reads then writes each clipped source pixel (so
// copies within one surface see pixels already written); flip copies the surface to a scratch
// plane and back, reading then writing each pixel. This stepping is set by the one write and
// one read port of the pixel memory. A new item is accepted while the previous result still
// waits in the output register.
module clipped_rect_blit_engine_unit #(
  parameter int SURFACES   = crbe_pkg::SURFACES_DEFAULT,
  parameter int MAX_WIDTH  = crbe_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = crbe_pkg::MAX_HEIGHT_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire crbe_pkg::req_item_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output crbe_pkg::rsp_item_t      rsp
);
  import crbe_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t stat;

  crbe_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  crbe_datapath #(
    .SURFACES   (SURFACES),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item accepted while another is in progress");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status <= ST_BOTH_INVALID))
    else $error("result status out of range");

  a_colour_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.pixel_color == 24'd0))
    else $error("colour returned with failing status");

endmodule
`default_nettype wire
